FILE: src/smp_pkg.sv
// Package for the SHA message padder: job word passed from the front end
// to the back end, command codes and padding constants. No dependencies.
package smp_pkg;

    // Input command codes
    localparam logic CMD_DATA   = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // Configuration: hash mode codes
    localparam logic MODE_SHA256 = 1'b0;   // 64-byte block, 8-byte length
    localparam logic MODE_SHA512 = 1'b1;   // 128-byte block, 16-byte length

    localparam logic [7:0] PAD_MARK      = 8'h80;
    localparam logic [7:0] BLOCK_BYTES_S = 8'd64;
    localparam logic [7:0] BLOCK_BYTES_L = 8'd128;
    localparam logic [7:0] MIN_PAD_S     = 8'd9;    // length field plus marker
    localparam logic [7:0] MIN_PAD_L     = 8'd17;
    localparam logic [3:0] FULL_WORD     = 4'd8;
    localparam logic [3:0] ONE_BYTE      = 4'd1;

    // One classified item: a message byte or a complete padding job
    typedef struct packed {
        logic        is_finish;
        logic [7:0]  data_byte;
        logic        mode;
        logic [3:0]  first_count;   // bytes in the first padding word
        logic [4:0]  word_total;    // padding words, 2 to 18
        logic [63:0] bit_len_low;
        logic [63:0] bit_len_high;
    } job_t;

endpackage

FILE: src/sha_message_padder_unit.sv
// SHA message padder, top level: front end, job queue and back end.
// Depends on smp_pkg, smp_front, smp_queue and smp_back.
//
// Usage:
//   Input channel (in_valid/in_ready): one word per item, command selects a
//   message byte (data_byte) or finish. Each message byte comes out as one
//   word, byte in the top lane, out_count 1, is_padding 0. Finish emits the
//   padding: 0x80, zeros to the block boundary, then the big-endian bit
//   length; an extra block is added when the length field does not fit.
//   Padding words carry 8 bytes, bar the first (n mod 8 bytes, or 8), and
//   the final word has last set. The byte counter clears after finish.
//   Config channel (cfg_valid/cfg_ready, always ready): hash_mode, 0 for a
//   64-byte block with 8-byte length, 1 for 128-byte block, 16-byte length.
//   Write it only while the block is idle; it is sampled at finish.
//   A word passes the job queue and then the output register on its way out.
//   Throughput: message bytes one per cycle while the receiver takes them; a
//   finish holds the back end for its padding words, 2 to 18 of them (one word
//   per cycle from the output register). The front keeps accepting until the
//   job queue (QUEUE_DEPTH entries) is full.
//   Reset: counter cleared, hash_mode 0, queue and output register empty.
//   A stalled receiver holds the output word; the queue then fills and
//   in_ready drops.
module sha_message_padder_unit #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [7:0]  data_byte,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        hash_mode,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] out_data,
    output logic [3:0]  out_count,
    output logic        is_padding,
    output logic        last
);
    import smp_pkg::*;

    job_t front_job;
    job_t head_job;
    logic q_can_push;
    logic q_head_valid;
    logic q_pop;
    logic in_take;

    assign cfg_ready = 1'b1;
    assign in_ready  = q_can_push;
    assign in_take   = in_valid && q_can_push;

    smp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid),
        .cfg_mode  (hash_mode),
        .in_take   (in_take),
        .command   (command),
        .data_byte (data_byte),
        .job       (front_job)
    );

    smp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (in_take),
        .push_job   (front_job),
        .can_push   (q_can_push),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_job   (head_job)
    );

    smp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_job   (head_job),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data),
        .out_count  (out_count),
        .is_padding (is_padding),
        .last       (last)
    );

    // Final padding word is always a full length word
    a_last_full: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> is_padding && (out_count == FULL_WORD))
        else $error("last word not a full padding word");

    // Pass-through words carry exactly one byte in the top lane
    a_data_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !is_padding |-> (out_count == ONE_BYTE) && !last
                                     && (out_data[55:0] == 56'd0))
        else $error("malformed data word");

    // A finish accepted with an empty pipeline produces a marker word once it has passed the queue and output register
    a_finish_marker: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && (command == CMD_FINISH) && !q_head_valid && !out_valid
        |=> ##1 out_valid && is_padding && (out_data[63:56] == PAD_MARK))
        else $error("padding does not open with the marker byte");

endmodule

FILE: src/smp_front.sv
// Front end of the SHA message padder: byte counter, mode register and
// classification of each input word into a job. Depends on smp_pkg.
module smp_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_mode,
    input  logic          in_take,
    input  logic          command,
    input  logic [7:0]    data_byte,
    output smp_pkg::job_t job
);
    import smp_pkg::*;

    logic        mode_reg, mode_next;
    logic [63:0] count_low_reg, count_low_next;
    logic [63:0] count_high_reg, count_high_next;

    logic [6:0]  used;
    logic [7:0]  block_bytes;
    logic [7:0]  min_pad;
    logic [7:0]  pad_raw;
    logic [7:0]  pad_len;
    logic [7:0]  pad_round;
    logic        is_finish;

    assign is_finish   = (command == CMD_FINISH);
    assign used        = (mode_reg == MODE_SHA512) ? count_low_reg[6:0]
                                                   : {1'b0, count_low_reg[5:0]};
    assign block_bytes = (mode_reg == MODE_SHA512) ? BLOCK_BYTES_L : BLOCK_BYTES_S;
    assign min_pad     = (mode_reg == MODE_SHA512) ? MIN_PAD_L : MIN_PAD_S;
    assign pad_raw     = block_bytes - {1'b0, used};
    assign pad_len     = (pad_raw < min_pad) ? pad_raw + block_bytes : pad_raw;
    assign pad_round   = pad_len + 8'd7;

    always_comb
    begin
        job              = '0;
        job.is_finish    = is_finish;
        job.data_byte    = data_byte;
        job.mode         = mode_reg;
        job.first_count  = (pad_len[2:0] == 3'd0) ? FULL_WORD : {1'b0, pad_len[2:0]};
        job.word_total   = pad_round[7:3];
        job.bit_len_low  = {count_low_reg[60:0], 3'b000};
        job.bit_len_high = {count_high_reg[60:0], count_low_reg[63:61]};
    end

    always_comb
    begin
        mode_next       = cfg_we ? cfg_mode : mode_reg;
        count_low_next  = count_low_reg;
        count_high_next = count_high_reg;
        if (in_take)
        begin
            if (is_finish)
            begin
                count_low_next  = '0;
                count_high_next = '0;
            end
            else
            begin
                count_low_next = count_low_reg + 64'd1;
                if (&count_low_reg)
                    count_high_next = count_high_reg + 64'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_SHA256;
            count_low_reg  <= '0;
            count_high_reg <= '0;
        end
        else
        begin
            mode_reg       <= mode_next;
            count_low_reg  <= count_low_next;
            count_high_reg <= count_high_next;
        end
    end

endmodule

FILE: src/smp_queue.sv
// Short job queue between front and back end of the SHA message padder.
// Show-ahead read of the head entry. Depends on smp_pkg.
module smp_queue #(
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  smp_pkg::job_t push_job,
    output logic          can_push,
    input  logic          pop,
    output logic          head_valid,
    output smp_pkg::job_t head_job
);
    import smp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    job_t             store [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] fill_reg, fill_next;

    assign can_push   = (fill_reg != FULL_CNT);
    assign head_valid = (fill_reg != '0);
    assign head_job   = store[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            fill_next = fill_reg + CNT_W'(1);
        else if (pop && !push)
            fill_next = fill_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

FILE: src/smp_back.sv
// Back end of the SHA message padder: walks each job into output words
// and holds them in the output register. Depends on smp_pkg.
module smp_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          head_valid,
    input  smp_pkg::job_t head_job,
    output logic          pop,
    output logic          out_valid,
    input  logic          out_ready,
    output logic [63:0]   out_data,
    output logic [3:0]    out_count,
    output logic          is_padding,
    output logic          last
);
    import smp_pkg::*;

    logic [4:0]  idx_reg, idx_next;
    logic        valid_reg, valid_next;
    logic [63:0] data_reg;
    logic [3:0]  count_reg;
    logic        pad_reg;
    logic        last_reg;

    logic [4:0]  rem;          // words still to follow this one
    logic        load;
    logic        head_done;
    logic [63:0] word;
    logic [3:0]  word_count;

    assign rem       = head_job.word_total - 5'd1 - idx_reg;
    assign load      = head_valid && (!valid_reg || out_ready);
    assign head_done = !head_job.is_finish || (rem == 5'd0);
    assign pop       = load && head_done;

    always_comb
    begin
        word       = '0;
        word_count = FULL_WORD;
        if (!head_job.is_finish)
        begin
            word       = {head_job.data_byte, 56'd0};
            word_count = ONE_BYTE;
        end
        else if (idx_reg == 5'd0)
        begin
            word       = {PAD_MARK, 56'd0};
            word_count = head_job.first_count;
        end
        else if (rem == 5'd0)
            word = head_job.bit_len_low;
        else if ((head_job.mode == MODE_SHA512) && (rem == 5'd1))
            word = head_job.bit_len_high;
    end

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            idx_next   = head_done ? 5'd0 : idx_reg + 5'd1;
            valid_next = 1'b1;
        end
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg  <= word;
            count_reg <= word_count;
            pad_reg   <= head_job.is_finish;
            last_reg  <= head_job.is_finish && (rem == 5'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_data   = data_reg;
    assign out_count  = count_reg;
    assign is_padding = pad_reg;
    assign last       = last_reg;

endmodule
